@@ hw/rtl/gdop_pkg.sv @@
package gdop_pkg;

  localparam int unsigned COORD_W     = 24;
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned MAX_ANCHORS = 64;
  localparam int unsigned MIN_ANCHORS = 4;
  localparam int unsigned CNT_W       = $clog2(MAX_ANCHORS + 2);
  localparam int unsigned GDOP_W      = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned FLOOR_W     = 32;
  localparam int unsigned SUM_W       = 40;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned QPTR_W      = $clog2(Q_DEPTH);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_SINGULAR = 2'd2,
    ST_MANY     = 2'd3
  } status_e;

  // one classified anchor: tag - anchor, accumulate flag, end of set, precheck
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic                     acc;
    logic                     last;
    status_e                  cls;
  } anchor_ent_t;

endpackage

@@ hw/rtl/gdop_if.sv @@
interface gdop_anchor_if;
  import gdop_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] anchor_x;
  logic signed [COORD_W-1:0] anchor_y;
  logic signed [COORD_W-1:0] anchor_z;
  logic signed [COORD_W-1:0] tag_x;
  logic signed [COORD_W-1:0] tag_y;
  logic signed [COORD_W-1:0] tag_z;
  logic                      last;
  modport source (output valid, anchor_x, anchor_y, anchor_z, tag_x, tag_y, tag_z, last,
                  input ready);
  modport sink   (input valid, anchor_x, anchor_y, anchor_z, tag_x, tag_y, tag_z, last,
                  output ready);
endinterface

interface gdop_result_if;
  import gdop_pkg::*;
  logic                valid;
  logic                ready;
  logic [GDOP_W-1:0]   gdop;
  logic [STATUS_W-1:0] status;
  modport source (output valid, gdop, status, input ready);
  modport sink   (input valid, gdop, status, output ready);
endinterface

interface gdop_cfg_if;
  import gdop_pkg::*;
  logic               valid;
  logic               ready;
  logic [FLOOR_W-1:0] det_floor;
  modport source (output valid, det_floor, input ready);
  modport sink   (input valid, det_floor, output ready);
endinterface

@@ hw/rtl/gdop_from_anchor_geometry.sv @@
// Back end per anchor: pop, 3 squares, 32-step square root, 1 load, 31-step triple
//   divide, then 6 products on one 32x32 multiplier.
// End of set: 13 bit-serial 128-bit MACs for cofactors and determinant, then the trace
//   and check states, 64 divide steps, a 32-step root and emit.
// The input takes a new anchor while the back end is busy, whenever the 2-entry queue has room.
// Reset (async, active low) clears sums, anchor count, queue and result; det_floor = 1.
module gdop_from_anchor_geometry (
  input  logic          clk_i,
  input  logic          rst_ni,
  gdop_anchor_if.sink   in_i,
  gdop_cfg_if.sink      cfg_i,
  gdop_result_if.source out_o
);
  import gdop_pkg::*;

  // front end: tag - anchor, count the set, classify the end-of-set status
  anchor_ent_t front_ent, back_ent;
  logic        push, full, pop, q_valid;

  gdop_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .ent_o  (front_ent)
  );

  // short queue decouples acceptance from the long per-anchor arithmetic
  gdop_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (front_ent),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .ent_o   (back_ent)
  );

  // back end: unit vector, H^T H sums, adjugate inverse, trace root;
  // holds the result in an output register until the sink takes it
  gdop_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ent_i   (back_ent),
    .pop_o   (pop),
    .cfg_i   (cfg_i),
    .out_o   (out_o)
  );

endmodule

@@ hw/rtl/gdop_front.sv @@
module gdop_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gdop_anchor_if.sink           in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output gdop_pkg::anchor_ent_t ent_o
);
  import gdop_pkg::*;

  logic [CNT_W-1:0]         cnt_q, cnt_d, cnt_inc;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic                     take;

  assign in_i.ready = !full_i;
  assign take       = in_i.valid && in_i.ready;
  assign push_o     = take;

  assign dx = DIFF_W'(in_i.tag_x) - DIFF_W'(in_i.anchor_x);
  assign dy = DIFF_W'(in_i.tag_y) - DIFF_W'(in_i.anchor_y);
  assign dz = DIFF_W'(in_i.tag_z) - DIFF_W'(in_i.anchor_z);

  // count saturates one past the limit
  assign cnt_inc = (cnt_q <= CNT_W'(MAX_ANCHORS)) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    ent_o.dx   = dx;
    ent_o.dy   = dy;
    ent_o.dz   = dz;
    ent_o.acc  = (cnt_q < CNT_W'(MAX_ANCHORS)) && ((dx != '0) || (dy != '0) || (dz != '0));
    ent_o.last = in_i.last;
    if (cnt_inc > CNT_W'(MAX_ANCHORS)) begin
      ent_o.cls = ST_MANY;
    end else if (cnt_inc < CNT_W'(MIN_ANCHORS)) begin
      ent_o.cls = ST_FEW;
    end else begin
      ent_o.cls = ST_OK;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (take) begin
      cnt_d = in_i.last ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/gdop_queue.sv @@
module gdop_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  gdop_pkg::anchor_ent_t ent_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output gdop_pkg::anchor_ent_t ent_o
);
  import gdop_pkg::*;

  anchor_ent_t       mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   n_q;

  assign full_o  = (n_q == (QPTR_W+1)'(Q_DEPTH));
  assign valid_o = (n_q != '0);
  assign ent_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      n_q  <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        n_q <= n_q + 1'b1;
      end else if (pop_i && !push_i) begin
        n_q <= n_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= ent_i;
    end
  end

endmodule

@@ hw/rtl/gdop_back.sv @@
module gdop_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  gdop_pkg::anchor_ent_t ent_i,
  output logic                  pop_o,
  gdop_cfg_if.sink              cfg_i,
  gdop_result_if.source         out_o
);
  import gdop_pkg::*;

  localparam int unsigned W        = 128;
  localparam int unsigned MG_W     = DIFF_W;
  localparam int unsigned R_W      = 26;
  localparam int unsigned FRAC     = 30;
  localparam int unsigned DIV_W    = R_W + FRAC;
  localparam int unsigned Q_W      = 31;
  localparam int unsigned MUL_W    = 32;
  localparam int unsigned P_W      = 2 * MUL_W;
  localparam int unsigned K_W      = 6;
  localparam int unsigned FLOOR_SH = 60;
  localparam int unsigned ROOT_IT  = 32;
  localparam int unsigned LDIV_IT  = 62;
  localparam logic [P_W-1:0] BIT0  = P_W'(1) << (P_W - 2);
  localparam logic [P_W-1:0] RND   = P_W'(1) << (FRAC - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_ROOT, S_DLD, S_DIV, S_PROD, S_FIN, S_MLD, S_MRUN,
    S_TR1, S_TR2, S_CHK1, S_CHK2, S_CHK3, S_DVH1, S_DVH2, S_DVL, S_EMIT
  } state_e;

  // cofactor and determinant sequence, two MACs per cofactor
  typedef enum logic [3:0] {
    M_C00A, M_C00B, M_C11A, M_C11B, M_C22A, M_C22B, M_C01A, M_C01B,
    M_C02A, M_C02B, M_DET0, M_DET1, M_DET2
  } mac_step_e;

  function automatic logic [MG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    mag = v[DIFF_W-1] ? MG_W'(-v) : MG_W'(v);
  endfunction

  state_e                  state_q, state_d;
  mac_step_e               step_q, step_d;
  anchor_ent_t             ent_q, ent_d;
  logic                    fin_q, fin_d;
  logic [K_W-1:0]          k_q, k_d;
  logic [MG_W-1:0]         mg_q [3];
  logic [MG_W-1:0]         mg_d [3];
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [P_W-1:0]          mul_q;
  logic [P_W-1:0]          n_q, n_d, res_q, res_d, bit_q, bit_d, rt_sum;
  logic [DIV_W-1:0]        rem_q [3];
  logic [DIV_W-1:0]        rem_d [3];
  logic [DIV_W-1:0]        dsh_q, dsh_d;
  logic [Q_W-1:0]          quo_q [3];
  logic [Q_W-1:0]          quo_d [3];
  logic [R_W-1:0]          r;
  logic signed [SUM_W-1:0] sums_q [6];
  logic signed [SUM_W-1:0] sums_d [6];
  logic [P_W-1:0]          prnd;
  logic signed [SUM_W-1:0] v;
  logic [2:0]              kp;
  logic                    pn;
  logic [2:0]              sg;
  logic [W-1:0]            c_q [5];
  logic [W-1:0]            c_d [5];
  logic [W-1:0]            det_q, det_d, acc_q, acc_d, acc_nx, ma_q, ma_d;
  logic [W-1:0]            dm_q, dm_d, tm_q, tm_d, rs, floor_w;
  logic [SUM_W-1:0]        mb_q, mb_d;
  logic                    sub_q, sub_d;
  logic                    dneg_q, dneg_d, tneg_q, tneg_d, tzero_q, tzero_d;
  logic [P_W-1:0]          q_q, q_d;
  logic [W-1:0]            mac_a;
  logic signed [SUM_W-1:0] mac_b;
  logic                    mac_neg, mac_first;
  logic [GDOP_W-1:0]       pend_gdop_q, pend_gdop_d, gdop_q, gdop_d;
  status_e                 pend_st_q, pend_st_d, st_q, st_d;
  logic                    ov_q, ov_d;
  logic [FLOOR_W-1:0]      floor_q;

  assign cfg_i.ready  = 1'b1;
  assign out_o.valid  = ov_q;
  assign out_o.gdop   = gdop_q;
  assign out_o.status = st_q;

  assign rt_sum  = res_q + bit_q;
  assign r       = res_q[R_W-1:0];
  assign prnd    = mul_q + RND;
  assign v       = SUM_W'(prnd[P_W-1:FRAC]);
  assign kp      = k_q[2:0] - 3'd1;
  assign sg      = {ent_q.dz[DIFF_W-1], ent_q.dy[DIFF_W-1], ent_q.dx[DIFF_W-1]};
  assign floor_w = W'({floor_q, {FLOOR_SH{1'b0}}});
  assign rs      = acc_q << 1;
  assign acc_nx  = mb_q[0] ? (sub_q ? acc_q - ma_q : acc_q + ma_q) : acc_q;

  // sign of the product for the pair being accumulated
  always_comb begin
    case (kp)
      3'd0:    pn = 1'b0;
      3'd1:    pn = sg[0] ^ sg[1];
      3'd2:    pn = sg[0] ^ sg[2];
      3'd3:    pn = 1'b0;
      3'd4:    pn = sg[1] ^ sg[2];
      default: pn = 1'b0;
    endcase
  end

  // sums: 0 xx, 1 xy, 2 xz, 3 yy, 4 yz, 5 zz; c: c00 c11 c22 c01 c02
  always_comb begin
    mac_a     = '0;
    mac_b     = '0;
    mac_neg   = 1'b0;
    mac_first = 1'b0;
    case (step_q)
      M_C00A: begin mac_a = W'(sums_q[3]); mac_b = sums_q[5]; mac_first = 1'b1; end
      M_C00B: begin mac_a = W'(sums_q[4]); mac_b = sums_q[4]; mac_neg = 1'b1; end
      M_C11A: begin mac_a = W'(sums_q[0]); mac_b = sums_q[5]; mac_first = 1'b1; end
      M_C11B: begin mac_a = W'(sums_q[2]); mac_b = sums_q[2]; mac_neg = 1'b1; end
      M_C22A: begin mac_a = W'(sums_q[0]); mac_b = sums_q[3]; mac_first = 1'b1; end
      M_C22B: begin mac_a = W'(sums_q[1]); mac_b = sums_q[1]; mac_neg = 1'b1; end
      M_C01A: begin mac_a = W'(sums_q[2]); mac_b = sums_q[4]; mac_first = 1'b1; end
      M_C01B: begin mac_a = W'(sums_q[1]); mac_b = sums_q[5]; mac_neg = 1'b1; end
      M_C02A: begin mac_a = W'(sums_q[1]); mac_b = sums_q[4]; mac_first = 1'b1; end
      M_C02B: begin mac_a = W'(sums_q[3]); mac_b = sums_q[2]; mac_neg = 1'b1; end
      M_DET0: begin mac_a = c_q[0]; mac_b = sums_q[0]; mac_first = 1'b1; end
      M_DET1: begin mac_a = c_q[3]; mac_b = sums_q[1]; end
      M_DET2: begin mac_a = c_q[4]; mac_b = sums_q[2]; end
      default: begin mac_a = '0; mac_b = '0; end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ent_d       = ent_q;
    fin_d       = fin_q;
    k_d         = k_q;
    mg_d        = mg_q;
    n_d         = n_q;
    res_d       = res_q;
    bit_d       = bit_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    sums_d      = sums_q;
    c_d         = c_q;
    det_d       = det_q;
    acc_d       = acc_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    sub_d       = sub_q;
    dm_d        = dm_q;
    tm_d        = tm_q;
    dneg_d      = dneg_q;
    tneg_d      = tneg_q;
    tzero_d     = tzero_q;
    q_d         = q_q;
    pend_gdop_d = pend_gdop_q;
    pend_st_d   = pend_st_q;
    gdop_d      = gdop_q;
    st_d        = st_q;
    ov_d        = ov_q;
    pop_o       = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o    = 1'b1;
          ent_d    = ent_i;
          mg_d[0]  = mag(ent_i.dx);
          mg_d[1]  = mag(ent_i.dy);
          mg_d[2]  = mag(ent_i.dz);
          n_d      = '0;
          res_d    = '0;
          bit_d    = BIT0;
          k_d      = '0;
          fin_d    = 1'b0;
          if (ent_i.acc) begin
            state_d = S_SQ;
          end else if (ent_i.last) begin
            state_d = S_FIN;
          end
        end
      end
      S_SQ: begin
        case (k_q[1:0])
          2'd0:    begin mul_a = MUL_W'(mg_q[0]); mul_b = MUL_W'(mg_q[0]); end
          2'd1:    begin mul_a = MUL_W'(mg_q[1]); mul_b = MUL_W'(mg_q[1]); end
          2'd2:    begin mul_a = MUL_W'(mg_q[2]); mul_b = MUL_W'(mg_q[2]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (k_q != '0) begin
          n_d = n_q + mul_q;
        end
        if (k_q == K_W'(3)) begin
          k_d     = '0;
          state_d = S_ROOT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_ROOT: begin
        if (n_q >= rt_sum) begin
          n_d   = n_q - rt_sum;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        k_d   = k_q + 1'b1;
        if (k_q == K_W'(ROOT_IT - 1)) begin
          k_d = '0;
          if (fin_q) begin
            pend_gdop_d = res_d[GDOP_W-1:0];
            pend_st_d   = ST_OK;
            state_d     = S_EMIT;
          end else begin
            state_d = S_DLD;
          end
        end
      end
      S_DLD: begin
        for (int i = 0; i < 3; i++) begin
          rem_d[i] = DIV_W'({mg_q[i], {FRAC{1'b0}}}) + DIV_W'(r >> 1);
          quo_d[i] = '0;
        end
        dsh_d   = {r, {FRAC{1'b0}}};
        k_d     = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= dsh_q) begin
            rem_d[i] = rem_q[i] - dsh_q;
            quo_d[i] = {quo_q[i][Q_W-2:0], 1'b1};
          end else begin
            quo_d[i] = {quo_q[i][Q_W-2:0], 1'b0};
          end
        end
        dsh_d = dsh_q >> 1;
        if (k_q == K_W'(Q_W - 1)) begin
          k_d     = '0;
          state_d = S_PROD;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_PROD: begin
        case (k_q[2:0])
          3'd0:    begin mul_a = MUL_W'(quo_q[0]); mul_b = MUL_W'(quo_q[0]); end
          3'd1:    begin mul_a = MUL_W'(quo_q[0]); mul_b = MUL_W'(quo_q[1]); end
          3'd2:    begin mul_a = MUL_W'(quo_q[0]); mul_b = MUL_W'(quo_q[2]); end
          3'd3:    begin mul_a = MUL_W'(quo_q[1]); mul_b = MUL_W'(quo_q[1]); end
          3'd4:    begin mul_a = MUL_W'(quo_q[1]); mul_b = MUL_W'(quo_q[2]); end
          3'd5:    begin mul_a = MUL_W'(quo_q[2]); mul_b = MUL_W'(quo_q[2]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (k_q != '0) begin
          sums_d[kp] = sums_q[kp] + (pn ? -v : v);
        end
        if (k_q == K_W'(6)) begin
          k_d     = '0;
          state_d = ent_q.last ? S_FIN : S_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_FIN: begin
        fin_d = 1'b1;
        if (ent_q.cls == ST_OK) begin
          step_d  = M_C00A;
          state_d = S_MLD;
        end else begin
          pend_gdop_d = '1;
          pend_st_d   = ent_q.cls;
          state_d     = S_EMIT;
        end
      end
      S_MLD: begin
        ma_d  = mac_a;
        mb_d  = mac_b[SUM_W-1] ? SUM_W'(-mac_b) : SUM_W'(mac_b);
        sub_d = mac_neg ^ mac_b[SUM_W-1];
        if (mac_first) begin
          acc_d = '0;
        end
        k_d     = '0;
        state_d = S_MRUN;
      end
      S_MRUN: begin
        acc_d = acc_nx;
        ma_d  = ma_q << 1;
        mb_d  = mb_q >> 1;
        if (k_q == K_W'(SUM_W - 1)) begin
          k_d = '0;
          case (step_q)
            M_C00B:  c_d[0] = acc_nx;
            M_C11B:  c_d[1] = acc_nx;
            M_C22B:  c_d[2] = acc_nx;
            M_C01B:  c_d[3] = acc_nx;
            M_C02B:  c_d[4] = acc_nx;
            M_DET2:  det_d  = acc_nx;
            default: det_d  = det_q;
          endcase
          if (step_q == M_DET2) begin
            state_d = S_TR1;
          end else begin
            step_d  = mac_step_e'(step_q + 1'b1);
            state_d = S_MLD;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_TR1: begin
        acc_d   = c_q[0] + c_q[1];
        state_d = S_TR2;
      end
      S_TR2: begin
        acc_d   = acc_q + c_q[2];
        state_d = S_CHK1;
      end
      S_CHK1: begin
        dm_d    = det_q[W-1] ? -det_q : det_q;
        tm_d    = acc_q[W-1] ? -acc_q : acc_q;
        dneg_d  = det_q[W-1];
        tneg_d  = acc_q[W-1];
        tzero_d = (acc_q == '0);
        state_d = S_CHK2;
      end
      S_CHK2: begin
        if ((dm_q == '0) || (dm_q < floor_w)) begin
          pend_gdop_d = '1;
          pend_st_d   = ST_SINGULAR;
          state_d     = S_EMIT;
        end else begin
          state_d = S_CHK3;
        end
      end
      S_CHK3: begin
        pend_st_d = ST_OK;
        if (tzero_q || (tneg_q != dneg_q)) begin
          pend_gdop_d = '0;
          state_d     = S_EMIT;
        end else if (tm_q >= (dm_q << 2)) begin
          pend_gdop_d = '1;
          state_d     = S_EMIT;
        end else begin
          acc_d   = tm_q;
          state_d = S_DVH1;
        end
      end
      S_DVH1: begin
        if (acc_q >= (dm_q << 1)) begin
          acc_d = acc_q - (dm_q << 1);
          q_d   = P_W'(2);
        end else begin
          q_d = '0;
        end
        state_d = S_DVH2;
      end
      S_DVH2: begin
        if (acc_q >= dm_q) begin
          acc_d = acc_q - dm_q;
          q_d   = q_q | P_W'(1);
        end
        k_d     = '0;
        state_d = S_DVL;
      end
      S_DVL: begin
        if (rs >= dm_q) begin
          acc_d = rs - dm_q;
          q_d   = {q_q[P_W-2:0], 1'b1};
        end else begin
          acc_d = rs;
          q_d   = {q_q[P_W-2:0], 1'b0};
        end
        if (k_q == K_W'(LDIV_IT - 1)) begin
          n_d     = q_d;
          res_d   = '0;
          bit_d   = BIT0;
          k_d     = '0;
          state_d = S_ROOT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (!ov_q || out_o.ready) begin
          ov_d   = 1'b1;
          gdop_d = pend_gdop_q;
          st_d   = pend_st_q;
          for (int i = 0; i < 6; i++) begin
            sums_d[i] = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      gdop_q  <= '0;
      st_q    <= ST_OK;
      floor_q <= FLOOR_W'(1);
      for (int i = 0; i < 6; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      gdop_q  <= gdop_d;
      st_q    <= st_d;
      sums_q  <= sums_d;
      if (cfg_i.valid && cfg_i.ready) begin
        floor_q <= cfg_i.det_floor;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q      <= step_d;
    ent_q       <= ent_d;
    fin_q       <= fin_d;
    k_q         <= k_d;
    mg_q        <= mg_d;
    mul_q       <= P_W'(mul_a * mul_b);
    n_q         <= n_d;
    res_q       <= res_d;
    bit_q       <= bit_d;
    rem_q       <= rem_d;
    dsh_q       <= dsh_d;
    quo_q       <= quo_d;
    c_q         <= c_d;
    det_q       <= det_d;
    acc_q       <= acc_d;
    ma_q        <= ma_d;
    mb_q        <= mb_d;
    sub_q       <= sub_d;
    dm_q        <= dm_d;
    tm_q        <= tm_d;
    dneg_q      <= dneg_d;
    tneg_q      <= tneg_d;
    tzero_q     <= tzero_d;
    q_q         <= q_d;
    pend_gdop_q <= pend_gdop_d;
    pend_st_q   <= pend_st_d;
  end

endmodule

@@ hw/rtl/gdop_checker.sv @@
module gdop_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [gdop_pkg::GDOP_W-1:0]   gdop_i,
  input logic [gdop_pkg::STATUS_W-1:0] status_i
);
  import gdop_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(gdop_i) && $stable(status_i))
    else $error("result changed while stalled");

  // every error status carries saturated gdop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> (gdop_i == '1))
    else $error("error status without saturated gdop");

  // no result right out of reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind gdop_from_anchor_geometry gdop_checker u_gdop_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .gdop_i      (out_o.gdop),
  .status_i    (out_o.status)
);

@@ tb/gdop_tb_if.sv @@
module gdop_tb_clock (
  output logic clk_o
);
  timeunit 1ns;
  timeprecision 1ps;
  initial begin
    clk_o = 1'b0;
    forever #1 clk_o = ~clk_o;
  end
endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gdop_pkg::*;

  // Clock and reset. Reset is asserted once, at time zero.
  logic clk_i;
  logic rst_ni;
  gdop_tb_clock u_clk (.clk_o(clk_i));

  gdop_anchor_if anc_if ();
  gdop_cfg_if    cfg_if ();
  gdop_result_if res_if ();

  gdop_from_anchor_geometry uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (anc_if.sink),
    .cfg_i (cfg_if.sink),
    .out_o (res_if.source)
  );

  // Predicted outcome of one anchor set.
  typedef struct packed {
    logic [GDOP_W-1:0] gdop;
    status_e           status;
  } gdop_result_t;

  // Shadow of the block state: normal-matrix sums, anchor count, floor.
  logic signed [63:0]  nm_sum [6];
  int unsigned         set_count;
  logic [FLOOR_W-1:0]  floor_shadow;

  gdop_result_t        pending_results[$];
  int unsigned         fail_count;
  int unsigned         result_count;
  int unsigned         anchor_txn_count;
  int unsigned         status_seen[4];
  longint unsigned     cycle_count;
  bit                  rx_stall_en;

  localparam longint unsigned CYCLE_LIMIT = 64'd10_000_000;

  // Integer square root, floor.
  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] bitv;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[63:0];
  endfunction

  // Add u*u^T of one tag-to-anchor difference into the sums.
  task automatic add_direction(input longint dv[3]);
    longint unsigned mg[3];
    longint unsigned mx;
    longint unsigned rr;
    longint unsigned q;
    longint unsigned p;
    longint          uv[3];
    longint          v;
    int              sh;
    int              k;
    sh = 0;
    k  = 0;
    for (int i = 0; i < 3; i++) mg[i] = (dv[i] < 0) ? -dv[i] : dv[i];
    mx = mg[0];
    if (mg[1] > mx) mx = mg[1];
    if (mg[2] > mx) mx = mg[2];
    if (mx == 0) return;   // coincident anchor: counted elsewhere, no contribution
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) mg[i] = mg[i] >> sh;
    rr = isqrt(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
    for (int i = 0; i < 3; i++) begin
      q     = ((mg[i] << 30) + (rr >> 1)) / rr;
      uv[i] = (dv[i] < 0) ? -longint'(q) : longint'(q);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = i; j < 3; j++) begin
        p = longint'(uv[i] < 0 ? -uv[i] : uv[i]) * longint'(uv[j] < 0 ? -uv[j] : uv[j]);
        v = longint'((p + (64'd1 << 29)) >> 30);
        nm_sum[k] = nm_sum[k] + (((uv[i] < 0) != (uv[j] < 0)) ? -v : v);
        k++;
      end
    end
  endtask

  // Inverse-trace square root of the normal matrix, with status.
  function automatic gdop_result_t close_set();
    gdop_result_t   r;
    logic signed [127:0] c00, c11, c22, c01, c02, det, tr, dm, tm, fl;
    logic [127:0]   rem;
    logic [63:0]    q;
    r.gdop   = '1;
    r.status = ST_OK;
    if (set_count > MAX_ANCHORS) begin
      r.status = ST_MANY;
      return r;
    end
    if (set_count < MIN_ANCHORS) begin
      r.status = ST_FEW;
      return r;
    end
    c00 = 128'(nm_sum[3]) * 128'(nm_sum[5]) - 128'(nm_sum[4]) * 128'(nm_sum[4]);
    c11 = 128'(nm_sum[0]) * 128'(nm_sum[5]) - 128'(nm_sum[2]) * 128'(nm_sum[2]);
    c22 = 128'(nm_sum[0]) * 128'(nm_sum[3]) - 128'(nm_sum[1]) * 128'(nm_sum[1]);
    c01 = 128'(nm_sum[2]) * 128'(nm_sum[4]) - 128'(nm_sum[1]) * 128'(nm_sum[5]);
    c02 = 128'(nm_sum[1]) * 128'(nm_sum[4]) - 128'(nm_sum[3]) * 128'(nm_sum[2]);
    det = 128'(nm_sum[0]) * c00 + 128'(nm_sum[1]) * c01 + 128'(nm_sum[2]) * c02;
    dm  = (det < 0) ? -det : det;
    fl  = 128'(floor_shadow) << 60;
    if (dm == 0 || dm < fl) begin
      r.status = ST_SINGULAR;
      return r;
    end
    tr = c00 + c11 + c22;
    if (tr == 0 || ((tr < 0) != (det < 0))) begin
      r.gdop = '0;   // zero or negative trace of the inverse clamps to zero
      return r;
    end
    tm = (tr < 0) ? -tr : tr;
    if (tm >= (dm << 2)) return r;   // trace of inverse 2^32 or more: saturate
    rem = tm % dm;
    q   = 64'(tm / dm);
    for (int i = 0; i < 62; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= dm) begin
        rem  = rem - dm;
        q[0] = 1'b1;
      end
    end
    r.gdop = 32'(isqrt(128'(q)));
    return r;
  endfunction

  // Update the shadow for one accepted anchor; queue a result on last.
  task automatic predict_anchor(input logic signed [COORD_W-1:0] ax, ay, az,
                                input logic signed [COORD_W-1:0] tx, ty, tz,
                                input logic lst);
    longint dv[3];
    dv[0] = longint'(tx) - longint'(ax);
    dv[1] = longint'(ty) - longint'(ay);
    dv[2] = longint'(tz) - longint'(az);
    if (set_count < MAX_ANCHORS) add_direction(dv);
    if (set_count <= MAX_ANCHORS) set_count++;
    if (lst) begin
      pending_results.push_back(close_set());
      for (int i = 0; i < 6; i++) nm_sum[i] = 0;
      set_count = 0;
    end
  endtask

  // Sender burst state: random-length bursts separated by random gaps.
  int unsigned burst_left;

  // Send one anchor transaction, inserting a gap at burst boundaries.
  // Valid stays high inside a burst; it drops only for a gap or a drain.
  task automatic send_anchor(input logic signed [COORD_W-1:0] ax, ay, az,
                             input logic signed [COORD_W-1:0] tx, ty, tz,
                             input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        anc_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    anc_if.valid    <= 1'b1;
    anc_if.anchor_x <= ax;
    anc_if.anchor_y <= ay;
    anc_if.anchor_z <= az;
    anc_if.tag_x    <= tx;
    anc_if.tag_y    <= ty;
    anc_if.tag_z    <= tz;
    anc_if.last     <= lst;
    @(posedge clk_i);
    while (!anc_if.ready) @(posedge clk_i);
    predict_anchor(ax, ay, az, tx, ty, tz, lst);
    anchor_txn_count++;
    burst_left--;
  endtask

  // Wait for every queued result, then let the end-of-set pipeline drain.
  task automatic wait_results_drained();
    anc_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  task automatic write_floor(input logic [FLOOR_W-1:0] value);
    wait_results_drained();
    cfg_if.valid     <= 1'b1;
    cfg_if.det_floor <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    floor_shadow = value;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [COORD_W-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return COORD_W'(-(1 << (COORD_W - 1)));
      1: return COORD_W'((1 << (COORD_W - 1)) - 1);
      2: return COORD_W'($urandom_range(0, 2000)) - COORD_W'(1000);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // One set of n anchors around a fixed tag. Shape selects the geometry.
  task automatic send_set(input int unsigned n, input int unsigned shape);
    logic signed [COORD_W-1:0] tx, ty, tz, ax, ay, az;
    tx = rnd_coord();
    ty = rnd_coord();
    tz = rnd_coord();
    for (int unsigned i = 0; i < n; i++) begin
      case (shape)
        0: begin   // general position
          ax = rnd_coord();
          ay = rnd_coord();
          az = rnd_coord();
        end
        1: begin   // planar: all anchors share the tag's z
          ax = rnd_coord();
          ay = rnd_coord();
          az = tz;
        end
        2: begin   // collinear along x
          ax = rnd_coord();
          ay = ty;
          az = tz;
        end
        default: begin   // mix in coincident anchors
          if ($urandom_range(0, 2) == 0) begin
            ax = tx;
            ay = ty;
            az = tz;
          end else begin
            ax = rnd_coord();
            ay = rnd_coord();
            az = rnd_coord();
          end
        end
      endcase
      send_anchor(ax, ay, az, tx, ty, tz, i == n - 1);
    end
  endtask

  // Corner coordinates, coincident anchors, fewer than four, singular sets.
  task automatic test_directed_sets();
    logic signed [COORD_W-1:0] lo, hi;
    lo = COORD_W'(-(1 << (COORD_W - 1)));
    hi = COORD_W'((1 << (COORD_W - 1)) - 1);
    // Tetrahedron at the coordinate extremes, tag at the far corner.
    send_anchor(lo, lo, lo, hi, hi, hi, 1'b0);
    send_anchor(hi, lo, lo, hi, hi, hi, 1'b0);
    send_anchor(lo, hi, lo, hi, hi, hi, 1'b0);
    send_anchor(lo, lo, hi, hi, hi, hi, 1'b1);
    // Axis anchors plus one coincident anchor and one off-axis anchor.
    send_anchor(24'sd1000, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_anchor(24'sd0, 24'sd1000, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_anchor(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_anchor(24'sd0, 24'sd0, -24'sd1000, 24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_anchor(-24'sd7, -24'sd9, 24'sd3, 24'sd0, 24'sd0, 24'sd0, 1'b1);
    // Single anchor set and three anchor set: fewer than four.
    send_anchor(24'sd5, 24'sd5, 24'sd5, 24'sd0, 24'sd0, 24'sd0, 1'b1);
    send_set(3, 0);
    // Collinear set, then all coincident: zero determinant.
    send_set(4, 2);
    send_anchor(hi, hi, hi, hi, hi, hi, 1'b0);
    send_anchor(lo, lo, lo, lo, lo, lo, 1'b0);
    send_anchor(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_anchor(24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 1'b1);
    // Planar geometry: singular.
    send_set(5, 1);
  endtask

  // Sets at and beyond the anchor limit.
  task automatic test_anchor_limit();
    send_set(MAX_ANCHORS, 0);
    send_set(MAX_ANCHORS + 1, 0);
    send_set(MAX_ANCHORS + 3, 3);
  endtask

  // Random sets, mostly well formed, over several det_floor settings.
  task automatic test_random_sets(input int unsigned n_anchors);
    int unsigned target;
    int unsigned sz;
    target = anchor_txn_count + n_anchors;
    while (anchor_txn_count < target) begin
      case ($urandom_range(0, 9))
        0:       sz = $urandom_range(1, 3);
        1:       sz = $urandom_range(MAX_ANCHORS - 2, MAX_ANCHORS + 2);
        default: sz = $urandom_range(4, 12);
      endcase
      send_set(sz, $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3));
      // Pause now and then until all results are back.
      if ($urandom_range(0, 30) == 0) wait_results_drained();
    end
  endtask

  // Receiver: stall pattern that alternates between stall-free and choppy stretches.
  initial begin
    res_if.ready = 1'b0;
    rx_stall_en  = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) rx_stall_en <= ~rx_stall_en;
      res_if.ready <= rx_stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    gdop_result_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result gdop=%h status=%0d", $time,
                 res_if.gdop, res_if.status);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        status_seen[exp_r.status]++;
        if (res_if.gdop !== exp_r.gdop) begin
          $display("%0t: gdop mismatch expected %h actual %h", $time,
                   exp_r.gdop, res_if.gdop);
          fail_count++;
        end
        if (res_if.status !== exp_r.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   exp_r.status, res_if.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** gdop_from_anchor_geometry: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    anc_if.valid     = 1'b0;
    anc_if.anchor_x  = '0;
    anc_if.anchor_y  = '0;
    anc_if.anchor_z  = '0;
    anc_if.tag_x     = '0;
    anc_if.tag_y     = '0;
    anc_if.tag_z     = '0;
    anc_if.last      = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.det_floor = '0;
    cycle_count      = 0;
    fail_count       = 0;
    result_count     = 0;
    anchor_txn_count = 0;
    burst_left       = 0;
    set_count        = 0;
    floor_shadow     = 32'd1;
    for (int i = 0; i < 6; i++) nm_sum[i] = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset floor first, then the extremes and a few settings in between.
    test_directed_sets();
    test_anchor_limit();
    test_random_sets(300);
    write_floor(32'd0);
    test_directed_sets();
    test_random_sets(250);
    write_floor(32'hFFFF_FFFF);
    test_random_sets(250);
    write_floor(32'h0000_4000);
    test_random_sets(300);
    write_floor($urandom);
    test_random_sets(300);
    write_floor(32'd1);
    test_random_sets(50);

    wait_results_drained();
    $display("covered %0d anchor transactions, %0d results", anchor_txn_count,
             result_count);
    $display("status counts ok=%0d few=%0d singular=%0d many=%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0) begin
      $display("** gdop_from_anchor_geometry: PASSED **");
    end else begin
      $display("** gdop_from_anchor_geometry: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gdop_pkg.sv
hw/rtl/gdop_if.sv
hw/rtl/gdop_front.sv
hw/rtl/gdop_queue.sv
hw/rtl/gdop_back.sv
hw/rtl/gdop_from_anchor_geometry.sv
hw/rtl/gdop_checker.sv
tb/gdop_tb_if.sv
tb/tb.sv
